// ----- rtl/sjf_pkg.sv -----
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared widths and defaults for the shortest-job-first scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;

  localparam int unsigned MaxProcsDef = 16;

  localparam int unsigned TimeW  = 16;
  localparam int unsigned IndexW = 4;
  localparam int unsigned ClockW = 21;
  localparam int unsigned TotalW = 25;

endpackage

// ----- rtl/sjf_nonpreemptive_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler_unit
// Non-preemptive shortest-job-first scheduler with a serial scan datapath.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): one transaction per process, with
// arrival and burst time. Loading accepts one transaction per cycle while
// in_stall_o is low; up to MAX_PROCS processes are kept, later ones are
// dropped. A transaction with last_process set closes the set and starts
// scheduling; in_stall_o stays high until the last result has been taken.
// Scheduling walks the stored entries one per cycle through a single memory
// read port and one compare datapath. For n processes a first scan finds the
// earliest arrival; then each pick takes one scan (two scans when the clock
// must jump to a pending arrival) and a commit step.
// Output channel (out_valid_o / out_stall_i): n transactions in load order,
// each read out once the previous one is taken; a stalled result holds its
// value. The totals carry the sums on the last transaction only and are
// zero elsewhere. Reset empties the set and drops any result in flight.
// ----------------------------------------------------------------------------
module sjf_nonpreemptive_scheduler_unit
  import sjf_pkg::*;
#(
  parameter int unsigned MAX_PROCS = MaxProcsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [TimeW-1:0]  arrival_time_i,
  input  logic [TimeW-1:0]  burst_time_i,
  input  logic              last_process_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IndexW-1:0] process_index_o,
  output logic [ClockW-1:0] completion_time_o,
  output logic [ClockW-1:0] turnaround_time_o,
  output logic [ClockW-1:0] waiting_time_o,
  output logic [TotalW-1:0] total_turnaround_o,
  output logic [TotalW-1:0] total_waiting_o,
  output logic              last_result_o
);

  localparam int unsigned IdxW = $clog2(MAX_PROCS);
  localparam int unsigned CntW = $clog2(MAX_PROCS + 1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_MIN      = 7'b0000010,
    S_PICK     = 7'b0000100,
    S_COMMIT   = 7'b0001000,
    S_OUT_RD   = 7'b0010000,
    S_OUT_LD   = 7'b0100000,
    S_OUT_WAIT = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       issue_q, issue_d;
  logic [CntW-1:0]       picks_q, picks_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]       rd_idx_q, rd_idx_d;
  logic [ClockW-1:0]     clock_q, clock_d;
  logic                  found_q, found_d;
  logic                  have_q, have_d;
  logic [TimeW-1:0]      best_q, best_d;
  logic [TimeW-1:0]      pend_q, pend_d;
  logic [IdxW-1:0]       pick_q, pick_d;
  logic [IdxW-1:0]       out_k_q, out_k_d;
  logic [MAX_PROCS-1:0]  done_q, done_d;
  logic [TotalW-1:0]     sum_tat_q, sum_tat_d;
  logic [TotalW-1:0]     sum_wt_q, sum_wt_d;

  logic                  out_valid_q, out_valid_d;
  logic [IndexW-1:0]     oidx_q, oidx_d;
  logic [ClockW-1:0]     ct_q, ct_d;
  logic [ClockW-1:0]     tat_q, tat_d;
  logic [ClockW-1:0]     wt_q, wt_d;
  logic [TotalW-1:0]     tot_tat_q, tot_tat_d;
  logic [TotalW-1:0]     tot_wt_q, tot_wt_d;
  logic                  olast_q, olast_d;

  logic [TimeW-1:0]      arr_mem [MAX_PROCS];
  logic [TimeW-1:0]      bur_mem [MAX_PROCS];
  logic [ClockW-1:0]     cmp_mem [MAX_PROCS];
  logic [TimeW-1:0]      arr_rd_q;
  logic [TimeW-1:0]      bur_rd_q;
  logic [ClockW-1:0]     cmp_rd_q;

  logic                  ld_we;
  logic                  cm_we;
  logic [IdxW-1:0]       rd_addr;
  logic [ClockW-1:0]     cm_data;
  logic                  in_acc;
  logic                  scan_end;
  logic                  elem_live;
  logic [ClockW-1:0]     tat_calc;
  logic [ClockW-1:0]     wt_calc;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign scan_end = rd_vld_q && (CntW'(rd_idx_q) == count_q - CntW'(1));
  assign elem_live = rd_vld_q && !done_q[rd_idx_q];
  assign tat_calc = cmp_rd_q - ClockW'(arr_rd_q);
  assign wt_calc  = tat_calc - ClockW'(bur_rd_q);

  always_comb begin
    if (state_q == S_OUT_RD) begin
      rd_addr = out_k_q;
    end else if (issue_q < count_q) begin
      rd_addr = issue_q[IdxW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_d     = issue_q;
    picks_d     = picks_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    clock_d     = clock_q;
    found_d     = found_q;
    have_d      = have_q;
    best_d      = best_q;
    pend_d      = pend_q;
    pick_d      = pick_q;
    out_k_d     = out_k_q;
    done_d      = done_q;
    sum_tat_d   = sum_tat_q;
    sum_wt_d    = sum_wt_q;
    out_valid_d = out_valid_q;
    oidx_d      = oidx_q;
    ct_d        = ct_q;
    tat_d       = tat_q;
    wt_d        = wt_q;
    tot_tat_d   = tot_tat_q;
    tot_wt_d    = tot_wt_q;
    olast_d     = olast_q;
    ld_we       = 1'b0;
    cm_we       = 1'b0;
    cm_data     = clock_q + ClockW'(best_q);

    if ((state_q == S_MIN) || (state_q == S_PICK)) begin
      if (issue_q < count_q) begin
        rd_vld_d = 1'b1;
        rd_idx_d = issue_q[IdxW-1:0];
        issue_d  = issue_q + CntW'(1);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (count_q < CntW'(MAX_PROCS)) begin
            ld_we = 1'b1;
            done_d[count_q[IdxW-1:0]] = 1'b0;
            count_d = count_q + CntW'(1);
          end
          if (last_process_i) begin
            state_d = S_MIN;
            issue_d = '0;
            picks_d = '0;
          end
        end
      end
      S_MIN: begin
        if (rd_vld_q && ((rd_idx_q == '0) || (arr_rd_q < pend_q))) begin
          pend_d = arr_rd_q;
        end
        if (scan_end) begin
          clock_d = ClockW'(pend_d);
          state_d = S_PICK;
          issue_d = '0;
          found_d = 1'b0;
          have_d  = 1'b0;
        end
      end
      S_PICK: begin
        if (elem_live && (ClockW'(arr_rd_q) <= clock_q) &&
            (!found_q || (bur_rd_q < best_q))) begin
          found_d = 1'b1;
          best_d  = bur_rd_q;
          pick_d  = rd_idx_q;
        end
        if (elem_live && (!have_q || (arr_rd_q < pend_q))) begin
          have_d = 1'b1;
          pend_d = arr_rd_q;
        end
        if (scan_end) begin
          if (found_d) begin
            state_d = S_COMMIT;
          end else begin
            clock_d = ClockW'(pend_d);
            issue_d = '0;
            found_d = 1'b0;
            have_d  = 1'b0;
          end
        end
      end
      S_COMMIT: begin
        cm_we   = 1'b1;
        clock_d = cm_data;
        done_d[pick_q] = 1'b1;
        picks_d = picks_q + CntW'(1);
        if (picks_d == count_q) begin
          state_d   = S_OUT_RD;
          out_k_d   = '0;
          sum_tat_d = '0;
          sum_wt_d  = '0;
        end else begin
          state_d = S_PICK;
          issue_d = '0;
          found_d = 1'b0;
          have_d  = 1'b0;
        end
      end
      S_OUT_RD: begin
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        sum_tat_d   = sum_tat_q + TotalW'(tat_calc);
        sum_wt_d    = sum_wt_q + TotalW'(wt_calc);
        olast_d     = (CntW'(out_k_q) == count_q - CntW'(1));
        oidx_d      = IndexW'(out_k_q);
        ct_d        = cmp_rd_q;
        tat_d       = tat_calc;
        wt_d        = wt_calc;
        tot_tat_d   = olast_d ? sum_tat_d : '0;
        tot_wt_d    = olast_d ? sum_wt_d : '0;
        out_valid_d = 1'b1;
        state_d     = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_valid_q && !out_stall_i) begin
          out_valid_d = 1'b0;
          if (olast_q) begin
            state_d = S_IDLE;
            count_d = '0;
            done_d  = '0;
          end else begin
            out_k_d = out_k_q + IdxW'(1);
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      picks_q     <= '0;
      rd_vld_q    <= 1'b0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      picks_q     <= picks_d;
      rd_vld_q    <= rd_vld_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    clock_q   <= clock_d;
    found_q   <= found_d;
    have_q    <= have_d;
    best_q    <= best_d;
    pend_q    <= pend_d;
    pick_q    <= pick_d;
    out_k_q   <= out_k_d;
    sum_tat_q <= sum_tat_d;
    sum_wt_q  <= sum_wt_d;
    oidx_q    <= oidx_d;
    ct_q      <= ct_d;
    tat_q     <= tat_d;
    wt_q      <= wt_d;
    tot_tat_q <= tot_tat_d;
    tot_wt_q  <= tot_wt_d;
    olast_q   <= olast_d;
  end

  // process tables, one read port shared by all scans
  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      arr_mem[count_q[IdxW-1:0]] <= arrival_time_i;
      bur_mem[count_q[IdxW-1:0]] <= burst_time_i;
    end
    if (cm_we) begin
      cmp_mem[pick_q] <= cm_data;
    end
    arr_rd_q <= arr_mem[rd_addr];
    bur_rd_q <= bur_mem[rd_addr];
    cmp_rd_q <= cmp_mem[rd_addr];
  end

  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign process_index_o    = oidx_q;
  assign completion_time_o  = ct_q;
  assign turnaround_time_o  = tat_q;
  assign waiting_time_o     = wt_q;
  assign total_turnaround_o = tot_tat_q;
  assign total_waiting_o    = tot_wt_q;
  assign last_result_o      = olast_q;

endmodule

// ----- rtl/sjf_chk.sv -----
// ----------------------------------------------------------------------------
// sjf_chk
// Port-level checks for the shortest-job-first scheduler.
// ----------------------------------------------------------------------------
module sjf_chk
  import sjf_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              last_process_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [ClockW-1:0] completion_time_o,
  input logic [TotalW-1:0] total_turnaround_o,
  input logic [TotalW-1:0] total_waiting_o,
  input logic              last_result_o
);

  // no new process is taken while results are pending
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while a result is pending");

  // a non-final process keeps the loader open
  a_load_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !last_process_i) |=> !in_stall_o)
    else $error("loader closed after a non-final process");

  // totals appear on the final result only
  a_totals_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_result_o) |->
      (total_turnaround_o == '0 && total_waiting_o == '0))
    else $error("nonzero totals on a non-final result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(completion_time_o)))
    else $error("stalled result changed");

endmodule

bind sjf_nonpreemptive_scheduler_unit sjf_chk u_sjf_chk (.*);

// ----- sim/tb_sjf_nonpreemptive_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// tb_sjf_nonpreemptive_scheduler_unit
// Self-checking testbench for the shortest-job-first scheduler. Process sets
// are loaded over the input channel. A built-in predictor schedules every set
// and checks each result transaction against the oldest expected result.
// Directed sets come first: a single process, field extremes, equal bursts,
// an idle clock jump and a full set. Random sets of mixed size follow, with
// some past capacity. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sjf_nonpreemptive_scheduler_unit;
  import sjf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemTarget    = 430;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 100;

  typedef enum int unsigned {
    PaceNone,
    PaceFull,
    PaceShort
  } pace_e;

  typedef struct {
    logic [IndexW-1:0] index;
    logic [ClockW-1:0] completion;
    logic [ClockW-1:0] turnaround;
    logic [ClockW-1:0] waiting;
    logic [TotalW-1:0] total_turnaround;
    logic [TotalW-1:0] total_waiting;
    logic              last;
  } sched_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [TimeW-1:0]  arrival_time_i;
  logic [TimeW-1:0]  burst_time_i;
  logic              last_process_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [IndexW-1:0] process_index_o;
  logic [ClockW-1:0] completion_time_o;
  logic [ClockW-1:0] turnaround_time_o;
  logic [ClockW-1:0] waiting_time_o;
  logic [TotalW-1:0] total_turnaround_o;
  logic [TotalW-1:0] total_waiting_o;
  logic              last_result_o;

  logic [TimeW-1:0] load_arrival [MaxProcsDef];
  logic [TimeW-1:0] load_burst   [MaxProcsDef];
  int unsigned      load_count = 0;

  sched_result_t pending_results [$];

  pace_e       in_pace  = PaceFull;
  pace_e       out_pace = PaceFull;
  int unsigned fail_count      = 0;
  int unsigned items_sent      = 0;
  int unsigned sets_scheduled  = 0;
  int unsigned results_checked = 0;
  int unsigned idle_cycles     = 0;

  sjf_nonpreemptive_scheduler_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .arrival_time_i     (arrival_time_i),
    .burst_time_i       (burst_time_i),
    .last_process_i     (last_process_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .process_index_o    (process_index_o),
    .completion_time_o  (completion_time_o),
    .turnaround_time_o  (turnaround_time_o),
    .waiting_time_o     (waiting_time_o),
    .total_turnaround_o (total_turnaround_o),
    .total_waiting_o    (total_waiting_o),
    .last_result_o      (last_result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned draw_wait(pace_e pace);
    case (pace)
      PaceFull:  return $urandom_range(0, 19);
      PaceShort: return $urandom_range(0, 2);
      default:   return 0;
    endcase
  endfunction

  function automatic void pick_pace();
    in_pace  = pace_e'($urandom_range(0, 2));
    out_pace = pace_e'($urandom_range(0, 2));
  endfunction

  // Runs the stored set to completion and queues one result per process.
  function automatic void schedule_set();
    logic [ClockW-1:0] sched_clock;
    logic [ClockW-1:0] finish [MaxProcsDef];
    logic [ClockW-1:0] tat;
    logic [ClockW-1:0] wt;
    logic [TotalW-1:0] sum_tat;
    logic [TotalW-1:0] sum_wt;
    logic [TimeW-1:0]  best;
    logic              done [MaxProcsDef];
    bit                found;
    int unsigned       pend;
    int unsigned       pick;
    int unsigned       n;
    sched_result_t     res;
    n = load_count;
    pick = 0;
    best = '0;
    sched_clock = ClockW'(load_arrival[0]);
    for (int j = 1; j < n; j++)
      if (load_arrival[j] < sched_clock) sched_clock = ClockW'(load_arrival[j]);
    for (int j = 0; j < MaxProcsDef; j++) done[j] = 1'b0;
    for (int i = 0; i < n; i++) begin
      found = 1'b0;
      for (int round = 0; round < 2 && !found; round++) begin
        if (round == 1) begin
          // nothing ready: jump to the earliest pending arrival
          pend = 32'h1_0000;
          for (int j = 0; j < n; j++)
            if (!done[j] && load_arrival[j] < pend) pend = 32'(load_arrival[j]);
          sched_clock = ClockW'(pend);
        end
        for (int j = 0; j < n; j++) begin
          if (!done[j] && load_arrival[j] <= sched_clock &&
              (!found || load_burst[j] < best)) begin
            found = 1'b1;
            best  = load_burst[j];
            pick  = j;
          end
        end
      end
      done[pick]   = 1'b1;
      sched_clock  = sched_clock + ClockW'(load_burst[pick]);
      finish[pick] = sched_clock;
    end
    sum_tat = '0;
    sum_wt  = '0;
    for (int k = 0; k < n; k++) begin
      tat     = finish[k] - ClockW'(load_arrival[k]);
      wt      = tat - ClockW'(load_burst[k]);
      sum_tat = sum_tat + TotalW'(tat);
      sum_wt  = sum_wt + TotalW'(wt);
      res.index            = IndexW'(k);
      res.completion       = finish[k];
      res.turnaround       = tat;
      res.waiting          = wt;
      res.total_turnaround = '0;
      res.total_waiting    = '0;
      res.last             = 1'b0;
      if (k == n - 1) begin
        res.total_turnaround = sum_tat;
        res.total_waiting    = sum_wt;
        res.last             = 1'b1;
      end
      pending_results.push_back(res);
    end
    load_count = 0;
    sets_scheduled++;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (load_count < MaxProcsDef) begin
        load_arrival[load_count] = arrival_time_i;
        load_burst[load_count]   = burst_time_i;
        load_count++;
      end
      if (last_process_i) schedule_set();
    end
  end

  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction, process_index %0d", process_index_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("process_index", 32'(want.index), 32'(process_index_o));
        check_field("completion_time", 32'(want.completion), 32'(completion_time_o));
        check_field("turnaround_time", 32'(want.turnaround), 32'(turnaround_time_o));
        check_field("waiting_time", 32'(want.waiting), 32'(waiting_time_o));
        check_field("total_turnaround", 32'(want.total_turnaround),
                    32'(total_turnaround_o));
        check_field("total_waiting", 32'(want.total_waiting), 32'(total_waiting_o));
        check_field("last_result", 32'(want.last), 32'(last_result_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("** sjf_nonpreemptive_scheduler_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      hold = draw_wait(out_pace);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_process(logic [TimeW-1:0] arrival, logic [TimeW-1:0] burst,
                              logic last);
    int unsigned gap;
    gap = draw_wait(in_pace);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    arrival_time_i <= arrival;
    burst_time_i   <= burst;
    last_process_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic test_single_process();
    send_process(16'd123, 16'd45, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_process(16'hFFFF, 16'hFFFF, 1'b0);
    send_process(16'h0000, 16'h0000, 1'b0);
    send_process(16'hFFFF, 16'h0000, 1'b1);
  endtask

  task automatic test_equal_bursts();
    send_process(16'd7, 16'd9, 1'b0);
    send_process(16'd3, 16'd9, 1'b0);
    send_process(16'd3, 16'd9, 1'b1);
  endtask

  task automatic test_idle_clock();
    send_process(16'd50, 16'd4, 1'b0);
    send_process(16'd0, 16'd1, 1'b0);
    send_process(16'd50, 16'd4, 1'b1);
  endtask

  task automatic test_full_set();
    for (int i = 0; i < MaxProcsDef; i++)
      send_process(16'hFFFF, 16'hFFFF, i == MaxProcsDef - 1);
  endtask

  task automatic test_set_overflow();
    for (int i = 0; i < MaxProcsDef + 2; i++)
      send_process(16'($urandom_range(0, 100)), 16'($urandom_range(0, 50)),
                   i == MaxProcsDef + 1);
  endtask

  task automatic test_random_sets();
    int unsigned roll;
    int unsigned size;
    int unsigned arr_base;
    int unsigned arr_span;
    int unsigned burst_span;
    while (items_sent < ItemTarget) begin
      pick_pace();
      roll = $urandom_range(0, 99);
      if (roll < 70)      size = $urandom_range(1, 6);
      else if (roll < 92) size = $urandom_range(7, MaxProcsDef);
      else                size = $urandom_range(MaxProcsDef + 1, MaxProcsDef + 4);
      case ($urandom_range(0, 3))
        0: begin arr_base = 0; arr_span = 65535; end
        1: begin arr_base = 0; arr_span = 30; end
        2: begin arr_base = $urandom_range(0, 65335); arr_span = 200; end
        default: begin arr_base = 0; arr_span = 2000; end
      endcase
      case ($urandom_range(0, 2))
        0: burst_span = 65535;
        1: burst_span = 15;
        default: burst_span = 500;
      endcase
      for (int i = 0; i < size; i++)
        send_process(16'(arr_base + $urandom_range(0, arr_span)),
                     16'($urandom_range(0, burst_span)), i == size - 1);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    arrival_time_i = '0;
    burst_time_i   = '0;
    last_process_i = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_process();
    test_field_extremes();
    test_equal_bursts();
    test_idle_clock();
    test_full_set();
    pick_pace();
    test_set_overflow();
    test_random_sets();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Scheduled %0d process sets from %0d transactions, %0d results checked.",
             sets_scheduled, items_sent, results_checked);
    $display("Included single, full and over-capacity sets, ties and idle clock jumps.");
    if (fail_count == 0) begin
      $display("** sjf_nonpreemptive_scheduler_unit: PASSED **");
    end else begin
      $display("** sjf_nonpreemptive_scheduler_unit: FAILED **");
    end
    $finish;
  end

endmodule
